// File: hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared constants and types for the LCS recovery block
// Sizes, item kinds, traceback directions and sequencer states.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int MAX_LEN   = 64;
   localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int SYM_W     = 8;
   localparam int KIND_W    = 2;
   localparam int DIR_W     = 2;
   localparam int DIR_AW    = 2 * IDX_W;
   localparam int DIR_DEPTH = 1 << DIR_AW;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST   = 2'd0,
      KIND_SECOND  = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_DIAG = 2'd0,
      DIR_UP   = 2'd1,
      DIR_LEFT = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_FILL,
      ST_TB_RD,
      ST_TB_ACT,
      ST_EM_RD,
      ST_EM_OUT,
      ST_EM_EMPTY
   } state_type;

endpackage

// File: hdl/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lcs_string_recovery.sv
// ----------------------------------------------------------------------------
// lcs_string_recovery: longest common subsequence with traceback
// Loads two byte strings, fills the LCS table and streams the subsequence out.
// ----------------------------------------------------------------------------
// Input beats carry a kind in req_tuser and a character in req_tdata. Kind 0
// appends to the first string, kind 1 to the second (at most MAX_LEN each;
// further characters are dropped and flag overflow), kind 2 runs the compute,
// kind 3 is ignored. A compute beat fills the length table one cell per
// cycle through the row and direction memories, then walks the direction
// memory back from the last cell, each step a read (ST_TB_RD) and an action
// (ST_TB_ACT), then reads the answer memory, one read (ST_EM_RD) and one
// output (ST_EM_OUT) per result beat, waiting there while the sink stalls.
// Results come out first character first, tlast on the final one; an empty
// subsequence gives a single beat with the empty flag set.
// Both string counts and the overflow flag clear when a compute finishes.
// The input is held off (req_tready low) for the whole compute; a result
// still waiting in the output register does not block new load beats.
// ----------------------------------------------------------------------------
module lcs_string_recovery (
   input  logic       clock,
   input  logic       reset,
   // request stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] kind
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] symbol_res
   output logic [1:0] rsp_tuser,   // [0] empty_res, [1] overflow
   output logic       rsp_tlast
);

   localparam int IDX_W = lcs_pkg::IDX_W;
   localparam int CNT_W = lcs_pkg::CNT_W;
   localparam int SYM_W = lcs_pkg::SYM_W;

   // ---------------------------------------------------------------- state
   lcs_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic             dropped_ff, dropped_in;

   // fill counters: row i (1-based), next column to read, pipeline stage
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_col_ff, s1_col_in;
   logic [CNT_W-1:0] diag_ff, diag_in;   // up[j-1]
   logic [CNT_W-1:0] left_ff, left_in;   // cur[j-1]

   // traceback position, answer length, emit index
   logic [CNT_W-1:0] ti_ff, ti_in;
   logic [CNT_W-1:0] tj_ff, tj_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] em_ff, em_in;

   // output register
   logic             rsp_valid_ff;
   logic [SYM_W-1:0] rsp_sym_ff;
   logic             rsp_empty_ff;
   logic             rsp_ovf_ff;
   logic             rsp_last_ff;
   logic             out_load;
   logic [SYM_W-1:0] out_sym;
   logic             out_empty;
   logic             out_last;

   // ---------------------------------------------------------------- memories
   logic                      ft_we, ft_re;
   logic [IDX_W-1:0]          ft_waddr, ft_raddr;
   logic [SYM_W-1:0]          ft_rdata;
   logic                      st_we, st_re;
   logic [IDX_W-1:0]          st_waddr, st_raddr;
   logic [SYM_W-1:0]          st_rdata;
   logic                      row_we, row_re;
   logic [IDX_W-1:0]          row_waddr, row_raddr;
   logic [CNT_W-1:0]          row_wdata, row_rdata;
   logic                      dir_we, dir_re;
   logic [lcs_pkg::DIR_AW-1:0] dir_waddr, dir_raddr;
   logic [lcs_pkg::DIR_W-1:0] dir_wdata, dir_rdata;
   logic                      ans_we, ans_re;
   logic [IDX_W-1:0]          ans_waddr, ans_raddr;
   logic [SYM_W-1:0]          ans_rdata;

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(lcs_pkg::MAX_LEN)) u_first_text (
      .clock(clock), .wr_en(ft_we), .wr_addr(ft_waddr), .wr_data(req_tdata),
      .rd_en(ft_re), .rd_addr(ft_raddr), .rd_data(ft_rdata)
   );

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(lcs_pkg::MAX_LEN)) u_second_text (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(req_tdata),
      .rd_en(st_re), .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // single length row: entry j-1 holds up[j] until overwritten with cur[j]
   lcs_ram #(.WIDTH(CNT_W), .DEPTH(lcs_pkg::MAX_LEN)) u_length_row (
      .clock(clock), .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
      .rd_en(row_re), .rd_addr(row_raddr), .rd_data(row_rdata)
   );

   lcs_ram #(.WIDTH(lcs_pkg::DIR_W), .DEPTH(lcs_pkg::DIR_DEPTH)) u_direction (
      .clock(clock), .wr_en(dir_we), .wr_addr(dir_waddr), .wr_data(dir_wdata),
      .rd_en(dir_re), .rd_addr(dir_raddr), .rd_data(dir_rdata)
   );

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(lcs_pkg::MAX_LEN)) u_answer (
      .clock(clock), .wr_en(ans_we), .wr_addr(ans_waddr), .wr_data(ft_rdata),
      .rd_en(ans_re), .rd_addr(ans_raddr), .rd_data(ans_rdata)
   );

   // ---------------------------------------------------------------- cell logic
   logic               req_fire;
   logic               out_free;
   lcs_pkg::kind_type  kind;
   logic [CNT_W-1:0]   i_dec, ti_dec, tj_dec, k_dec;
   logic [CNT_W-1:0]   up_val;
   logic [CNT_W-1:0]   cur_val;
   lcs_pkg::dir_type   cur_dir;
   logic               s1_last;

   always_comb begin
      i_dec  = i_ff - CNT_W'(1);
      ti_dec = ti_ff - CNT_W'(1);
      tj_dec = tj_ff - CNT_W'(1);
      k_dec  = k_ff - CNT_W'(1);
      // the row above the first row is all zeros
      up_val = (i_ff == CNT_W'(1)) ? '0 : row_rdata;
      if (ft_rdata == st_rdata) begin
         cur_val = diag_ff + CNT_W'(1);
         cur_dir = lcs_pkg::DIR_DIAG;
      end else if (up_val >= left_ff) begin
         cur_val = up_val;
         cur_dir = lcs_pkg::DIR_UP;
      end else begin
         cur_val = left_ff;
         cur_dir = lcs_pkg::DIR_LEFT;
      end
      s1_last = (CNT_W'(s1_col_ff) + CNT_W'(1)) == second_count_ff;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      kind       = lcs_pkg::kind_type'(req_tuser);
      req_tready = (state_ff == lcs_pkg::ST_IDLE);
      req_fire   = req_tvalid && req_tready;
      out_free   = !rsp_valid_ff || rsp_tready;

      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      issue_in        = issue_ff;
      s1_valid_in     = 1'b0;
      s1_col_in       = s1_col_ff;
      diag_in         = diag_ff;
      left_in         = left_ff;
      ti_in           = ti_ff;
      tj_in           = tj_ff;
      k_in            = k_ff;
      em_in           = em_ff;

      out_load  = 1'b0;
      out_sym   = '0;
      out_empty = 1'b0;
      out_last  = 1'b0;

      ft_we     = 1'b0;
      ft_waddr  = first_count_ff[IDX_W-1:0];
      ft_re     = 1'b0;
      ft_raddr  = i_dec[IDX_W-1:0];
      st_we     = 1'b0;
      st_waddr  = second_count_ff[IDX_W-1:0];
      st_re     = 1'b0;
      st_raddr  = issue_ff[IDX_W-1:0];
      row_we    = 1'b0;
      row_waddr = s1_col_ff;
      row_wdata = cur_val;
      row_re    = 1'b0;
      row_raddr = issue_ff[IDX_W-1:0];
      dir_we    = 1'b0;
      dir_waddr = {i_dec[IDX_W-1:0], s1_col_ff};
      dir_wdata = cur_dir;
      dir_re    = 1'b0;
      dir_raddr = {ti_dec[IDX_W-1:0], tj_dec[IDX_W-1:0]};
      ans_we    = 1'b0;
      ans_waddr = k_ff[IDX_W-1:0];
      ans_re    = 1'b0;
      ans_raddr = em_ff;

      case (state_ff)
         lcs_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  lcs_pkg::KIND_FIRST: begin
                     if (first_count_ff < CNT_W'(lcs_pkg::MAX_LEN)) begin
                        ft_we          = 1'b1;
                        first_count_in = first_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lcs_pkg::KIND_SECOND: begin
                     if (second_count_ff < CNT_W'(lcs_pkg::MAX_LEN)) begin
                        st_we           = 1'b1;
                        second_count_in = second_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lcs_pkg::KIND_COMPUTE: begin
                     if (first_count_ff == '0 || second_count_ff == '0) begin
                        state_in = lcs_pkg::ST_EM_EMPTY;
                     end else begin
                        i_in     = CNT_W'(1);
                        state_in = lcs_pkg::ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end

         lcs_pkg::ST_ROW: begin
            // fetch first_text[i-1]; it stays on the read port for the row
            ft_re    = 1'b1;
            issue_in = '0;
            diag_in  = '0;
            left_in  = '0;
            state_in = lcs_pkg::ST_FILL;
         end

         lcs_pkg::ST_FILL: begin
            if (issue_ff < second_count_ff) begin
               row_re      = 1'b1;
               st_re       = 1'b1;
               s1_valid_in = 1'b1;
               s1_col_in   = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end
            if (s1_valid_ff) begin
               row_we  = 1'b1;
               dir_we  = 1'b1;
               left_in = cur_val;
               diag_in = up_val;
               if (s1_last) begin
                  if (i_ff == first_count_ff) begin
                     ti_in    = first_count_ff;
                     tj_in    = second_count_ff;
                     k_in     = '0;
                     state_in = lcs_pkg::ST_TB_RD;
                  end else begin
                     i_in     = i_ff + CNT_W'(1);
                     state_in = lcs_pkg::ST_ROW;
                  end
               end
            end
         end

         lcs_pkg::ST_TB_RD: begin
            if (ti_ff == '0 || tj_ff == '0) begin
               if (k_ff == '0) begin
                  state_in = lcs_pkg::ST_EM_EMPTY;
               end else begin
                  em_in    = k_dec[IDX_W-1:0];
                  state_in = lcs_pkg::ST_EM_RD;
               end
            end else begin
               dir_re   = 1'b1;
               ft_re    = 1'b1;
               ft_raddr = ti_dec[IDX_W-1:0];
               state_in = lcs_pkg::ST_TB_ACT;
            end
         end

         lcs_pkg::ST_TB_ACT: begin
            case (lcs_pkg::dir_type'(dir_rdata))
               lcs_pkg::DIR_DIAG: begin
                  ans_we = 1'b1;
                  k_in   = k_ff + CNT_W'(1);
                  ti_in  = ti_dec;
                  tj_in  = tj_dec;
               end
               lcs_pkg::DIR_UP: begin
                  ti_in = ti_dec;
               end
               default: begin
                  tj_in = tj_dec;
               end
            endcase
            state_in = lcs_pkg::ST_TB_RD;
         end

         lcs_pkg::ST_EM_RD: begin
            ans_re   = 1'b1;
            state_in = lcs_pkg::ST_EM_OUT;
         end

         lcs_pkg::ST_EM_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_sym  = ans_rdata;
               out_last = (em_ff == '0);
               if (em_ff == '0) begin
                  first_count_in  = '0;
                  second_count_in = '0;
                  dropped_in      = 1'b0;
                  state_in        = lcs_pkg::ST_IDLE;
               end else begin
                  em_in    = em_ff - IDX_W'(1);
                  state_in = lcs_pkg::ST_EM_RD;
               end
            end
         end

         lcs_pkg::ST_EM_EMPTY: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_empty       = 1'b1;
               out_last        = 1'b1;
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
               state_in        = lcs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lcs_pkg::ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         s1_valid_ff     <= s1_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      issue_ff  <= issue_in;
      s1_col_ff <= s1_col_in;
      diag_ff   <= diag_in;
      left_ff   <= left_in;
      ti_ff     <= ti_in;
      tj_ff     <= tj_in;
      k_ff      <= k_in;
      em_ff     <= em_in;
      if (out_load) begin
         rsp_sym_ff   <= out_sym;
         rsp_empty_ff <= out_empty;
         rsp_ovf_ff   <= dropped_ff;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: tb/tb_lcs_string_recovery.sv
// ----------------------------------------------------------------------------
// tb_lcs_string_recovery: self-checking bench for the LCS recovery block
// Streams string loads and compute beats into the block and predicts every
// result beat from its own LCS table and traceback. Both stream sides idle
// and stall at random. One long sink hold lets the block back up its input.
// ----------------------------------------------------------------------------
module tb_lcs_string_recovery;
   timeunit 1ns;
   timeprecision 1ps;

   // kind 3 has no meaning in the block; it must be swallowed without effect
   localparam logic [lcs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RUN_ITEMS     = 500;        // load/compute beats to offer
   localparam int CYCLE_LIMIT   = 1_000_000;  // well past the slowest legal run
   localparam int LONG_HOLD     = 400;        // one long sink stall, in cycles
   localparam int SETTLE_CYCLES = 100;        // quiet time after the last result

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the two strings, runs the LCS table and traceback on
   // each compute beat and queues the result beats it must produce.
   // -------------------------------------------------------------------------
   class lcs_scoreboard;
      typedef struct {
         logic [7:0] symbol;
         logic       empty;
         logic       overflow;
         logic       last;
      } result_type;

      result_type       pending[$];      // result beats still owed by the block
      logic [7:0]       first_str[lcs_pkg::MAX_LEN];
      logic [7:0]       second_str[lcs_pkg::MAX_LEN];
      int               first_len;
      int               second_len;
      logic             dropped;
      int               len_grid[lcs_pkg::MAX_LEN+1][lcs_pkg::MAX_LEN+1];
      lcs_pkg::dir_type dir_grid[lcs_pkg::MAX_LEN][lcs_pkg::MAX_LEN];
      int               mismatches;
      int               computes;
      int               empty_computes;
      int               overflow_computes;
      int               beats_checked;

      function new();
         first_len  = 0;
         second_len = 0;
         dropped    = 1'b0;
      endfunction

      function void note_request(logic [lcs_pkg::KIND_W-1:0] kind, logic [7:0] symbol);
         case (kind)
            lcs_pkg::KIND_FIRST: begin
               if (first_len < lcs_pkg::MAX_LEN) begin
                  first_str[first_len] = symbol;
                  first_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            lcs_pkg::KIND_SECOND: begin
               if (second_len < lcs_pkg::MAX_LEN) begin
                  second_str[second_len] = symbol;
                  second_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            lcs_pkg::KIND_COMPUTE: recover_subsequence();
            default: ;
         endcase
      endfunction

      // Fill the length table, walk it back from the bottom-right cell and
      // queue the common subsequence first character first.
      function void recover_subsequence();
         logic [7:0] chars[$];
         result_type item;
         int         row;
         int         col;
         for (row = 0; row <= first_len; row++) len_grid[row][0] = 0;
         for (col = 0; col <= second_len; col++) len_grid[0][col] = 0;
         for (row = 1; row <= first_len; row++) begin
            for (col = 1; col <= second_len; col++) begin
               if (first_str[row-1] == second_str[col-1]) begin
                  len_grid[row][col]     = len_grid[row-1][col-1] + 1;
                  dir_grid[row-1][col-1] = lcs_pkg::DIR_DIAG;
               end else if (len_grid[row-1][col] >= len_grid[row][col-1]) begin
                  // tie goes up
                  len_grid[row][col]     = len_grid[row-1][col];
                  dir_grid[row-1][col-1] = lcs_pkg::DIR_UP;
               end else begin
                  len_grid[row][col]     = len_grid[row][col-1];
                  dir_grid[row-1][col-1] = lcs_pkg::DIR_LEFT;
               end
            end
         end
         row = first_len;
         col = second_len;
         while (row > 0 && col > 0) begin
            case (dir_grid[row-1][col-1])
               lcs_pkg::DIR_DIAG: begin
                  chars.push_front(first_str[row-1]);
                  row--;
                  col--;
               end
               lcs_pkg::DIR_UP: row--;
               default: col--;
            endcase
         end
         computes++;
         if (dropped) overflow_computes++;
         if (chars.size() == 0) begin
            empty_computes++;
            item.symbol   = 8'h00;
            item.empty    = 1'b1;
            item.overflow = dropped;
            item.last     = 1'b1;
            pending.push_back(item);
         end else begin
            foreach (chars[k]) begin
               item.symbol   = chars[k];
               item.empty    = 1'b0;
               item.overflow = dropped;
               item.last     = (k == chars.size() - 1);
               pending.push_back(item);
            end
         end
         first_len  = 0;
         second_len = 0;
         dropped    = 1'b0;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [7:0] symbol, logic [1:0] flags, logic last);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: result beat with nothing expected, symbol %0h flags %b last %b",
                     $time, symbol, flags, last);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         beats_checked++;
         compare_field("symbol", want.symbol, symbol);
         compare_field("empty", 8'(want.empty), 8'(flags[0]));
         compare_field("overflow", 8'(want.overflow), 8'(flags[1]));
         compare_field("tlast", 8'(want.last), 8'(last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'h00;   // [7:0] symbol
   logic [lcs_pkg::KIND_W-1:0] req_tuser  = lcs_pkg::KIND_FIRST;  // [1:0] kind
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;           // [7:0] symbol_res
   logic [1:0]                 rsp_tuser;           // [0] empty_res, [1] overflow
   logic                       rsp_tlast;

   lcs_scoreboard sb = new();

   int   cycles         = 0;
   int   items_sent     = 0;   // load and compute beats, kind 3 not counted
   bit   steady         = 1'b0; // both sides run without gaps while set
   bit   long_hold_done = 1'b0;

   lcs_string_recovery i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d result beats outstanding",
                  cycles, sb.pending.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Result sink: samples the handshake at the edge, then picks tready for the
   // next cycle. After the third checked beat it holds off for one long stall
   // so the block backs up and drops req_tready.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         end
         if (hold > 0) begin
            hold--;
         end else if (!long_hold_done && sb.beats_checked >= 3) begin
            hold           = LONG_HOLD;
            long_hold_done = 1'b1;
         end else begin
            hold = pick_gap();
         end
         rsp_tready <= (hold == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // One beat: optional gap, then hold tvalid until the block takes it.
   task automatic send_item(logic [lcs_pkg::KIND_W-1:0] kind, logic [7:0] symbol);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= symbol;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, symbol);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // Sender pause: nothing offered until every owed result beat has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   // Two strings of n and m characters drawn from a window of span symbols,
   // loads interleaved at random with the odd kind-3 beat mixed in. Without
   // a compute the strings carry over into the next case.
   task automatic run_case(int n, int m, int span, bit with_compute);
      int base;
      int done_first;
      int done_second;
      base        = $urandom_range(0, 256 - span);
      done_first  = 0;
      done_second = 0;
      while (done_first < n || done_second < m) begin
         if ($urandom_range(0, 39) == 0) send_item(KIND_UNUSED, 8'($urandom));
         if (done_second >= m || (done_first < n && $urandom_range(0, 1) == 1)) begin
            send_item(lcs_pkg::KIND_FIRST, 8'(base + $urandom_range(0, span - 1)));
            done_first++;
         end else begin
            send_item(lcs_pkg::KIND_SECOND, 8'(base + $urandom_range(0, span - 1)));
            done_second++;
         end
      end
      if (with_compute) send_item(lcs_pkg::KIND_COMPUTE, 8'($urandom));
   endtask

   initial begin : stimulus
      int roll;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // both strings empty
      send_item(lcs_pkg::KIND_COMPUTE, 8'h00);
      // ignored kind, then only the first string loaded
      send_item(KIND_UNUSED, 8'hFF);
      send_item(lcs_pkg::KIND_FIRST, 8'h00);
      send_item(lcs_pkg::KIND_COMPUTE, 8'hFF);
      // crossed pair: mismatch tie, traceback must step up
      send_item(lcs_pkg::KIND_FIRST, 8'hFF);
      send_item(lcs_pkg::KIND_FIRST, 8'h00);
      send_item(lcs_pkg::KIND_SECOND, 8'h00);
      send_item(lcs_pkg::KIND_SECOND, 8'hFF);
      send_item(lcs_pkg::KIND_COMPUTE, 8'h00);
      // ABC against AC; the long sink hold lands around here
      send_item(lcs_pkg::KIND_FIRST, 8'h41);
      send_item(lcs_pkg::KIND_FIRST, 8'h42);
      send_item(lcs_pkg::KIND_FIRST, 8'h43);
      send_item(lcs_pkg::KIND_SECOND, 8'h41);
      send_item(lcs_pkg::KIND_SECOND, 8'h43);
      send_item(lcs_pkg::KIND_COMPUTE, 8'hA5);
      // nothing in common
      send_item(lcs_pkg::KIND_FIRST, 8'h01);
      send_item(lcs_pkg::KIND_SECOND, 8'h02);
      send_item(lcs_pkg::KIND_COMPUTE, 8'h5A);
      // ignored kind between loads must not disturb either string
      send_item(lcs_pkg::KIND_FIRST, 8'hAA);
      send_item(KIND_UNUSED, 8'h55);
      send_item(lcs_pkg::KIND_SECOND, 8'hAA);
      send_item(lcs_pkg::KIND_COMPUTE, 8'h00);
      wait_drained();

      // --- random ---
      // full-length single-symbol strings past capacity: 64 beats plus overflow
      run_case(66, 65, 1, 1'b1);
      // both strings exactly full, no overflow
      run_case(64, 64, 4, 1'b1);
      while (items_sent < RUN_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         roll   = $urandom_range(0, 99);
         if (roll < 80) begin
            run_case($urandom_range(0, 10), $urandom_range(0, 10),
                     1 << $urandom_range(1, 8), $urandom_range(0, 19) != 0);
         end else if (roll < 95) begin
            run_case($urandom_range(0, 30), $urandom_range(0, 30),
                     1 << $urandom_range(1, 8), $urandom_range(0, 19) != 0);
         end else begin
            run_case($urandom_range(55, 70), $urandom_range(55, 70),
                     1 << $urandom_range(1, 3), 1'b1);
         end
         if ($urandom_range(0, 7) == 0) wait_drained();
      end
      steady = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d load/compute beats and %0d computes (%0d empty, %0d overflow),",
               items_sent, sb.computes, sb.empty_computes, sb.overflow_computes);
      $display("with %0d result beats checked under random stalls on both sides.",
               sb.beats_checked);
      if (sb.pending.size() != 0) begin
         $display("%0d expected result beats never arrived", sb.pending.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/lcs_pkg.sv
hdl/lcs_ram.sv
hdl/lcs_string_recovery.sv
tb/tb_lcs_string_recovery.sv
